// ===== design/dxt_pkg.sv =====
// ----------------------------------------------------------------------------
// dxt_pkg
// shared types, register codes and color helpers for the dxt block decoder
// ----------------------------------------------------------------------------
package dxt_pkg;

    localparam int TEXELS      = 16;
    localparam int TEXEL_CNT_W = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_DATA_W-1:0] BACKGROUND_RESET = 24'hFF_FFFF;

    // multiply-by-reciprocal for floor(v / 3), exact for v up to 765
    localparam logic [9:0] RECIP3 = 10'd683;

    typedef enum logic [0:0] {
        REG_TEXTURE_FORMAT   = 1'b0,
        REG_BACKGROUND_COLOR = 1'b1
    } dxt_reg_t;

    typedef enum logic [0:0] {
        FMT_DXT1 = 1'b0,
        FMT_DXT3 = 1'b1
    } dxt_fmt_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } dxt_rgb_t;

    typedef struct packed {
        dxt_rgb_t [3:0] palette;
        logic [31:0]    index_bits;
    } dxt_blk_t;

    // plain shift widening, low bits stay zero
    function automatic dxt_rgb_t expand565(input logic [15:0] c);
        dxt_rgb_t rgb;
        rgb.red   = {c[15:11], 3'b000};
        rgb.green = {c[10:5], 2'b00};
        rgb.blue  = {c[4:0], 3'b000};
        return rgb;
    endfunction

    // floor((2a + b) / 3)
    function automatic logic [7:0] blend_third(input logic [7:0] a, input logic [7:0] b);
        logic [9:0]  sum;
        logic [19:0] prod;
        sum  = {1'b0, a, 1'b0} + {2'b00, b};
        prod = sum * RECIP3;
        return prod[18:11];
    endfunction

    // floor((a + b) / 2)
    function automatic logic [7:0] blend_half(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8:1];
    endfunction

endpackage

// ===== design/dxt_blk_if.sv =====
// ----------------------------------------------------------------------------
// dxt_blk_if
// compressed block channel: two rgb565 end colors and 32 selector bits
// ----------------------------------------------------------------------------
interface dxt_blk_if;

    logic        valid;
    logic        ready;
    logic [15:0] first_color;
    logic [15:0] second_color;
    logic [31:0] index_bits;

    modport source (
        output valid,
        output first_color,
        output second_color,
        output index_bits,
        input  ready
    );

    modport sink (
        input  valid,
        input  first_color,
        input  second_color,
        input  index_bits,
        output ready
    );

endinterface

// ===== design/dxt_texel_if.sv =====
// ----------------------------------------------------------------------------
// dxt_texel_if
// decoded texel channel: position, rgb888 color and end-of-block flag
// ----------------------------------------------------------------------------
interface dxt_texel_if;

    logic       valid;
    logic       ready;
    logic [1:0] pixel_x;
    logic [1:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_texel;

    modport source (
        output valid,
        output pixel_x,
        output pixel_y,
        output red,
        output green,
        output blue,
        output last_texel,
        input  ready
    );

    modport sink (
        input  valid,
        input  pixel_x,
        input  pixel_y,
        input  red,
        input  green,
        input  blue,
        input  last_texel,
        output ready
    );

endinterface

// ===== design/dxt_texture_block_decode.sv =====
// ----------------------------------------------------------------------------
// dxt_texture_block_decode
// dxt1 / dxt3 color block decoder: one compressed block in, sixteen texels out
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  blocks     in   valid/ready    first_color, second_color, index_bits
//  texels     out  valid/ready    pixel_x, pixel_y, red, green, blue, last_texel
//  cfg        in   cfg_wr_en      cfg_index, cfg_data
//
//  the texel walker in the back emits a block's sixteen texels, one per cycle unless stalled
//  the palette is built combinationally and registered in the front; the first texel
//  then passes a queue entry, the back block register and the texel output register
//  the front accepts up to three blocks ahead while texels are stalled
//  rst_n clears all control state; registers reset to dxt1 and a white background
// ----------------------------------------------------------------------------
module dxt_texture_block_decode (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  dxt_pkg::dxt_reg_t               cfg_index,
    input  logic [dxt_pkg::CFG_DATA_W-1:0]  cfg_data,
    dxt_blk_if.sink                         blocks,
    dxt_texel_if.source                     texels
);
    import dxt_pkg::*;

    dxt_fmt_t  texture_format_reg;
    dxt_rgb_t  background_color_reg;
    logic      q_in_valid;
    logic      q_in_ready;
    dxt_blk_t  q_in_data;
    logic      q_out_valid;
    logic      q_out_ready;
    dxt_blk_t  q_out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            texture_format_reg   <= FMT_DXT1;
            background_color_reg <= BACKGROUND_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TEXTURE_FORMAT:   texture_format_reg   <= dxt_fmt_t'(cfg_data[0]);
                REG_BACKGROUND_COLOR: background_color_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    dxt_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .texture_format   (texture_format_reg),
        .background_color (background_color_reg),
        .blocks           (blocks),
        .q_valid          (q_in_valid),
        .q_ready          (q_in_ready),
        .q_data           (q_in_data)
    );

    dxt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    dxt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_out_valid),
        .q_ready (q_out_ready),
        .q_data  (q_out_data),
        .texels  (texels)
    );

endmodule

// ===== design/dxt_front.sv =====
// ----------------------------------------------------------------------------
// dxt_front
// accepts a block, picks four- or three-color mode and builds its palette
// ----------------------------------------------------------------------------
module dxt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  dxt_pkg::dxt_fmt_t texture_format,
    input  dxt_pkg::dxt_rgb_t background_color,
    dxt_blk_if.sink           blocks,
    output logic              q_valid,
    input  logic              q_ready,
    output dxt_pkg::dxt_blk_t q_data
);
    import dxt_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    dxt_blk_t  data_reg;
    dxt_blk_t  data_next;
    dxt_rgb_t  e0;
    dxt_rgb_t  e1;
    logic      four_color;
    logic      accept;

    assign blocks.ready = !valid_reg || q_ready;
    assign accept       = blocks.valid && blocks.ready;

    always_comb
    begin
        e0 = expand565(blocks.first_color);
        e1 = expand565(blocks.second_color);
        // strict compare: in dxt1 equal end colors fall into three-color mode
        four_color = (texture_format == FMT_DXT3) ||
                     (blocks.first_color > blocks.second_color);

        data_next.index_bits = blocks.index_bits;
        data_next.palette[0] = e0;
        data_next.palette[1] = e1;
        if (four_color)
        begin
            data_next.palette[2].red   = blend_third(e0.red,   e1.red);
            data_next.palette[2].green = blend_third(e0.green, e1.green);
            data_next.palette[2].blue  = blend_third(e0.blue,  e1.blue);
            data_next.palette[3].red   = blend_third(e1.red,   e0.red);
            data_next.palette[3].green = blend_third(e1.green, e0.green);
            data_next.palette[3].blue  = blend_third(e1.blue,  e0.blue);
        end
        else
        begin
            data_next.palette[2].red   = blend_half(e0.red,   e1.red);
            data_next.palette[2].green = blend_half(e0.green, e1.green);
            data_next.palette[2].blue  = blend_half(e0.blue,  e1.blue);
            data_next.palette[3]       = background_color;
        end
    end

    assign valid_next = accept || (valid_reg && !q_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = data_reg;

endmodule

// ===== design/dxt_queue.sv =====
// ----------------------------------------------------------------------------
// dxt_queue
// two-entry queue of classified blocks between front and back
// ----------------------------------------------------------------------------
module dxt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dxt_pkg::dxt_blk_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output dxt_pkg::dxt_blk_t out_data
);
    import dxt_pkg::*;

    dxt_blk_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic [QUEUE_CNT_W-1:0]   count_next;
    logic                     push;
    logic                     pop;

    assign in_ready  = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_ptr_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QUEUE_CNT_W'(QUEUE_DEPTH))
            |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

// ===== design/dxt_back.sv =====
// ----------------------------------------------------------------------------
// dxt_back
// walks a block's sixteen texels row-major, one per cycle unless stalled
// ----------------------------------------------------------------------------
module dxt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  dxt_pkg::dxt_blk_t q_data,
    dxt_texel_if.source       texels
);
    import dxt_pkg::*;

    localparam logic [TEXEL_CNT_W-1:0] LAST_CNT = TEXEL_CNT_W'(TEXELS - 1);

    dxt_blk_t                 blk_reg;
    logic                     busy_reg;
    logic                     busy_next;
    logic [TEXEL_CNT_W-1:0]   cnt_reg;
    logic [TEXEL_CNT_W-1:0]   cnt_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [1:0]               out_x_reg;
    logic [1:0]               out_y_reg;
    dxt_rgb_t                 out_rgb_reg;
    logic                     out_last_reg;
    logic                     load;
    logic                     pop;
    logic [1:0]               sel;

    // texel (x,y) selector sits at bit 8y+2x, which is twice the count
    assign sel     = blk_reg.index_bits[{cnt_reg, 1'b0} +: 2];
    assign load    = busy_reg && (!out_valid_reg || texels.ready);
    assign q_ready = !busy_reg || (load && cnt_reg == LAST_CNT);
    assign pop     = q_valid && q_ready;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_CNT)
            begin
                busy_next = 1'b0;
            end
        end
        if (pop)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    assign out_valid_next = load || (out_valid_reg && !texels.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            blk_reg <= q_data;
        end
        if (load)
        begin
            out_x_reg    <= cnt_reg[1:0];
            out_y_reg    <= cnt_reg[3:2];
            out_rgb_reg  <= blk_reg.palette[sel];
            out_last_reg <= cnt_reg == LAST_CNT;
        end
    end

    assign texels.valid      = out_valid_reg;
    assign texels.pixel_x    = out_x_reg;
    assign texels.pixel_y    = out_y_reg;
    assign texels.red        = out_rgb_reg.red;
    assign texels.green      = out_rgb_reg.green;
    assign texels.blue       = out_rgb_reg.blue;
    assign texels.last_texel = out_last_reg;

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_x_reg == 2'd3 && out_y_reg == 2'd3))
        else $error("last flag away from the final texel");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (cnt_reg == '0))
        else $error("texel count left over while idle");

    a_last_load: assert property (@(posedge clk) disable iff (!rst_n)
        (load && cnt_reg == LAST_CNT) |=> (out_valid_reg && out_last_reg))
        else $error("final texel not flagged");

endmodule
